### hw/rtl/jss_pkg.sv
`timescale 1ns / 1ps

package jss_pkg;

  // Default joystick sample width
  localparam int SAMPLE_BITS = 12;

  // Angles in 1/64 degree, duty on a 14-bit scale
  localparam int ANGLE_W = 14;
  localparam int DUTY_W  = 14;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // Angle limits: 50, 130 and 90 degrees, and their sum for axis inversion
  localparam logic [ANGLE_W-1:0] ANG_MIN    = 14'd3200;
  localparam logic [ANGLE_W-1:0] ANG_MAX    = 14'd8320;
  localparam logic [ANGLE_W-1:0] ANG_MID    = 14'd5760;
  localparam logic [ANGLE_W-1:0] ANG_MIRROR = 14'd11520;

  // duty = floor((a + 2880) * 16383 / 115200), with 115200 = 512 * 225
  localparam logic [ANGLE_W-1:0] DUTY_BIAS  = 14'd2880;
  localparam int                 DUTY_SHIFT = 19;
  localparam int                 DUTY_DIV   = 225;
  localparam int                 DUTY_RECIP = (1 << DUTY_SHIFT) / DUTY_DIV;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_GAIN = 3'd0,
    REG_DEADZONE    = 3'd1,
    REG_SLEW_STEP   = 3'd2,
    REG_SNAP        = 3'd3,
    REG_TRIM_X      = 3'd4,
    REG_TRIM_Y      = 3'd5
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_FIX,
    ST_DONE
  } seq_state_e;

  // Reset values of the registers
  localparam logic [7:0]  RST_FILTER_GAIN = 8'd31;
  localparam logic [10:0] RST_DEADZONE    = 11'd350;
  localparam logic [9:0]  RST_SLEW_STEP   = 10'd32;
  localparam logic [9:0]  RST_SNAP        = 10'd19;
  localparam logic [11:0] RST_TRIM_X      = 12'hF40;  // -192
  localparam logic [11:0] RST_TRIM_Y      = 12'hD00;  // -768

  // Settings seen by one axis lane
  typedef struct packed {
    logic [7:0]  filter_gain;
    logic [10:0] deadzone_width;
    logic [9:0]  slew_step;
    logic [9:0]  snap_threshold;
    logic [11:0] trim;
  } lane_cfg_t;

  // Step strobes from the sequencer to the lanes
  typedef struct packed {
    logic start;  // transaction accepted: filter or slew
    logic op;     // operation of the transaction in flight
    logic map;    // level to angle estimate, duty numerator
    logic fix;    // goal correction, duty estimate
  } lane_ctrl_t;

endpackage

### hw/rtl/jss_if.sv
`timescale 1ns / 1ps

interface jss_in_if import jss_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [SampleBits-1:0] sample_x;
  logic [SampleBits-1:0] sample_y;

  modport source (output valid, operation, sample_x, sample_y, input ready);
  modport sink   (input valid, operation, sample_x, sample_y, output ready);
endinterface

interface jss_out_if import jss_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] level_x;
  logic [SampleBits-1:0] level_y;
  logic [ANGLE_W-1:0]    position_x;
  logic [ANGLE_W-1:0]    position_y;
  logic [DUTY_W-1:0]     duty_x;
  logic [DUTY_W-1:0]     duty_y;

  modport source (output valid, level_x, level_y, position_x, position_y, duty_x, duty_y,
                  input ready);
  modport sink   (input valid, level_x, level_y, position_x, position_y, duty_x, duty_y,
                  output ready);
endinterface

### hw/rtl/joystick_servo_slew_drive.sv
`timescale 1ns / 1ps
// Two-axis joystick to servo drive.
// in_i carries one transaction per item: operation 0 with an X/Y pair of
// ADC samples (filter, deadzone, map to a goal angle), or operation 1, a
// tick that slews both angles towards their goals.
// out_o returns one transaction per item: both filtered levels, both
// angles in 1/64 degree and both 14-bit 50 Hz servo duties.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i by the
// user only while the block is idle; the block does not enforce this.
// Indexes above 5 are ignored. Each item runs through the four-step
// sequencer shared by the X and Y lanes (filter or slew, map and duty
// numerator, two reciprocal corrections). Its result passes the MAP,
// FIX and DONE states into the output register, and the next item is
// accepted only after that, so items do not overlap.
// Reset: filters at mid scale, goals and angles at 90 degrees, registers
// at their defaults, no result pending.
// Stall: one result waits in the output register while the next item is
// accepted and worked; that item then holds in its last step until the
// output register is free.
module joystick_servo_slew_drive import jss_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  jss_in_if.sink               in_i,
  jss_out_if.source            out_o
);

  // Configuration registers
  logic [7:0]  filter_gain_q;
  logic [10:0] deadzone_q;
  logic [9:0]  slew_step_q;
  logic [9:0]  snap_q;
  logic [11:0] trim_x_q;
  logic [11:0] trim_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_gain_q <= RST_FILTER_GAIN;
      deadzone_q    <= RST_DEADZONE;
      slew_step_q   <= RST_SLEW_STEP;
      snap_q        <= RST_SNAP;
      trim_x_q      <= RST_TRIM_X;
      trim_y_q      <= RST_TRIM_Y;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FILTER_GAIN: filter_gain_q <= cfg_data_i[7:0];
        REG_DEADZONE:    deadzone_q    <= cfg_data_i[10:0];
        REG_SLEW_STEP:   slew_step_q   <= cfg_data_i[9:0];
        REG_SNAP:        snap_q        <= cfg_data_i[9:0];
        REG_TRIM_X:      trim_x_q      <= cfg_data_i;
        REG_TRIM_Y:      trim_y_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  seq_state_e state_q, state_d;
  logic       op_q;
  logic       accept;
  logic       in_ready;
  logic       load;
  logic       free;
  lane_ctrl_t ctrl;

  assign accept = in_i.valid && in_ready;

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: state_d = ST_FIX;
      ST_FIX: state_d = ST_DONE;
      ST_DONE: begin
        if (free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SAMPLE;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= in_i.operation;
      end
    end
  end

  assign in_i.ready = in_ready;

  always_comb begin
    ctrl.start = accept;
    ctrl.op    = accept ? in_i.operation : op_q;
    ctrl.map   = (state_q == ST_MAP);
    ctrl.fix   = (state_q == ST_FIX);
  end

  // Lane settings
  lane_cfg_t cfg_x, cfg_y;

  always_comb begin
    cfg_x.filter_gain    = filter_gain_q;
    cfg_x.deadzone_width = deadzone_q;
    cfg_x.slew_step      = slew_step_q;
    cfg_x.snap_threshold = snap_q;
    cfg_x.trim           = trim_x_q;
    cfg_y                = cfg_x;
    cfg_y.trim           = trim_y_q;
  end

  // Axis lanes
  logic [SampleBits-1:0] level_x, level_y;
  logic [ANGLE_W-1:0]    position_x, position_y;
  logic [DUTY_W-1:0]     duty_x, duty_y;

  jss_lane #(.SampleBits(SampleBits)) u_lane_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_x),
    .invert_i   (1'b1),
    .sample_i   (in_i.sample_x),
    .level_o    (level_x),
    .position_o (position_x),
    .duty_o     (duty_x)
  );

  jss_lane #(.SampleBits(SampleBits)) u_lane_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_y),
    .invert_i   (1'b0),
    .sample_i   (in_i.sample_y),
    .level_o    (level_y),
    .position_o (position_y),
    .duty_o     (duty_y)
  );

  // Output register
  jss_merge #(.SampleBits(SampleBits)) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .free_o       (free),
    .level_x_i    (level_x),
    .level_y_i    (level_y),
    .position_x_i (position_x),
    .position_y_i (position_y),
    .duty_x_i     (duty_x),
    .duty_y_i     (duty_y),
    .out_o        (out_o)
  );

endmodule

### hw/rtl/jss_lane.sv
`timescale 1ns / 1ps

module jss_lane import jss_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_ctrl_t            ctrl_i,
  input  lane_cfg_t             cfg_i,
  input  logic                  invert_i,
  input  logic [SampleBits-1:0] sample_i,
  output logic [SampleBits-1:0] level_o,
  output logic [ANGLE_W-1:0]    position_o,
  output logic [DUTY_W-1:0]     duty_o
);

  localparam int SmW  = SampleBits + 8;   // smoothed value, 8 fraction bits
  localparam int NW   = SampleBits + 13;  // level * 5120
  localparam int DzW  = ((SampleBits > 11) ? SampleBits : 11) + 1;
  localparam int RcW  = 14;
  localparam longint unsigned FullScale = (64'd1 << SampleBits) - 64'd1;
  localparam logic [RcW-1:0]  MapRecip  = RcW'((64'd1 << NW) / FullScale);
  localparam logic [SampleBits-1:0] Mid = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [11:0]     DutyRecip = 12'(DUTY_RECIP);

  // Axis state
  logic [SmW-1:0]     smooth_q, smooth_d;
  logic [ANGLE_W-1:0] goal_q, goal_d;
  logic [ANGLE_W-1:0] angle_q, angle_d;

  // Pipeline payload
  logic [NW-1:0]  n_q;
  logic [RcW-1:0] mq_q;
  logic           dead_q;
  logic [18:0]    dx_q;
  logic [11:0]    dq_q;

  // Filter: s' = s + floor(g * ((v << 8) - s) / 256)
  logic signed [SmW:0]   sm_diff;
  logic signed [SmW+9:0] sm_prod;
  logic signed [SmW+1:0] sm_step;
  logic [SmW+1:0]        sm_sum;

  always_comb begin
    sm_diff  = $signed({1'b0, sample_i, 8'h00}) - $signed({1'b0, smooth_q});
    sm_prod  = sm_diff * $signed({1'b0, cfg_i.filter_gain});
    sm_step  = sm_prod[SmW+9:8];
    sm_sum   = unsigned'($signed({2'b00, smooth_q}) + sm_step);
    smooth_d = sm_sum[SmW-1:0];
  end

  // Slew: snap when close, else step towards the goal without passing it
  logic signed [ANGLE_W:0] sl_diff;
  logic [ANGLE_W:0]        sl_abs;
  logic [ANGLE_W:0]        sl_up;
  logic signed [ANGLE_W:0] sl_dn;

  always_comb begin
    sl_diff = $signed({1'b0, goal_q}) - $signed({1'b0, angle_q});
    sl_abs  = sl_diff[ANGLE_W] ? unsigned'(-sl_diff) : unsigned'(sl_diff);
    sl_up   = {1'b0, angle_q} + {5'b00000, cfg_i.slew_step};
    sl_dn   = $signed({1'b0, angle_q}) - $signed({5'b00000, cfg_i.slew_step});
    priority if (sl_abs < {5'b00000, cfg_i.snap_threshold}) begin
      angle_d = goal_q;
    end else if (angle_q < goal_q) begin
      angle_d = (sl_up > {1'b0, goal_q}) ? goal_q : sl_up[ANGLE_W-1:0];
    end else if (angle_q > goal_q) begin
      angle_d = (sl_dn < $signed({1'b0, goal_q})) ? goal_q : sl_dn[ANGLE_W-1:0];
    end else begin
      angle_d = angle_q;
    end
  end

  // Map step: deadzone test and level * 5120 / FullScale estimate (low by at most one)
  logic [SampleBits-1:0] level;
  logic [SampleBits-1:0] dz_dist;
  logic [NW-1:0]         n_val;
  logic [NW+RcW-1:0]     n_prod;

  always_comb begin
    level   = smooth_q[SmW-1:8];
    dz_dist = (level >= Mid) ? (level - Mid) : (Mid - level);
    n_val   = NW'({level, 12'h000}) + NW'({level, 10'h000});
    n_prod  = NW'(n_val) * (NW+RcW)'(MapRecip);
  end

  // Duty numerator: clamp angle plus trim, then ((a + 2880) * 16383) >> 9
  logic signed [15:0] a_sum;
  logic [ANGLE_W-1:0] a_clamp;
  logic [ANGLE_W-1:0] a_bias;
  logic [27:0]        a_scaled;

  always_comb begin
    a_sum = $signed({2'b00, angle_q}) + $signed({{4{cfg_i.trim[11]}}, cfg_i.trim});
    priority if (a_sum < $signed({2'b00, ANG_MIN})) begin
      a_clamp = ANG_MIN;
    end else if (a_sum > $signed({2'b00, ANG_MAX})) begin
      a_clamp = ANG_MAX;
    end else begin
      a_clamp = a_sum[ANGLE_W-1:0];
    end
    a_bias   = a_clamp + DUTY_BIAS;
    a_scaled = {a_bias, 14'h0000} - 28'(a_bias);
  end

  // Fix step: correct the map quotient, mirror for an inverted axis
  logic [NW+1:0]      m_rem;
  logic [RcW-1:0]     m_q;
  logic [ANGLE_W-1:0] m_ang;
  logic [30:0]        d_prod;

  always_comb begin
    m_rem  = (NW+2)'(n_q) + (NW+2)'(mq_q) - ((NW+2)'(mq_q) << SampleBits);
    m_q    = (m_rem >= (NW+2)'(FullScale)) ? mq_q + 1'b1 : mq_q;
    m_ang  = ANG_MIN + m_q;
    d_prod = 31'(dx_q) * 31'(DutyRecip);
    goal_d = goal_q;
    if (ctrl_i.op == OP_SAMPLE) begin
      if (dead_q) begin
        goal_d = ANG_MID;
      end else begin
        goal_d = invert_i ? (ANG_MIRROR - m_ang) : m_ang;
      end
    end
  end

  // Final duty correction
  logic [19:0] d_rem;

  always_comb begin
    d_rem  = 20'(dx_q) - 20'(dq_q) * 20'(DUTY_DIV);
    duty_o = (d_rem >= 20'(DUTY_DIV)) ? DUTY_W'(dq_q + 1'b1) : DUTY_W'(dq_q);
  end

  // Axis state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= {Mid, 8'h00};
      goal_q   <= ANG_MID;
      angle_q  <= ANG_MID;
    end else begin
      if (ctrl_i.start) begin
        if (ctrl_i.op == OP_SAMPLE) begin
          smooth_q <= smooth_d;
        end else begin
          angle_q <= angle_d;
        end
      end
      if (ctrl_i.fix) begin
        goal_q <= goal_d;
      end
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.map) begin
      n_q    <= n_val;
      mq_q   <= n_prod[NW+RcW-1:NW];
      dead_q <= (DzW'(dz_dist) < DzW'(cfg_i.deadzone_width));
      dx_q   <= a_scaled[27:9];
    end
    if (ctrl_i.fix) begin
      dq_q <= d_prod[30:19];
    end
  end

  assign level_o    = level;
  assign position_o = angle_q;

endmodule

### hw/rtl/jss_merge.sv
`timescale 1ns / 1ps

module jss_merge import jss_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  output logic                  free_o,
  input  logic [SampleBits-1:0] level_x_i,
  input  logic [SampleBits-1:0] level_y_i,
  input  logic [ANGLE_W-1:0]    position_x_i,
  input  logic [ANGLE_W-1:0]    position_y_i,
  input  logic [DUTY_W-1:0]     duty_x_i,
  input  logic [DUTY_W-1:0]     duty_y_i,
  jss_out_if.source             out_o
);

  logic                  valid_q, valid_d;
  logic [SampleBits-1:0] level_x_q, level_y_q;
  logic [ANGLE_W-1:0]    position_x_q, position_y_q;
  logic [DUTY_W-1:0]     duty_x_q, duty_y_q;

  // Register is free when empty or being drained this cycle
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Join both lanes into one result transaction
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      level_x_q    <= level_x_i;
      level_y_q    <= level_y_i;
      position_x_q <= position_x_i;
      position_y_q <= position_y_i;
      duty_x_q     <= duty_x_i;
      duty_y_q     <= duty_y_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.level_x    = level_x_q;
  assign out_o.level_y    = level_y_q;
  assign out_o.position_x = position_x_q;
  assign out_o.position_y = position_y_q;
  assign out_o.duty_x     = duty_x_q;
  assign out_o.duty_y     = duty_y_q;

endmodule

### tb/joystick_servo_slew_drive_test.sv
`timescale 1ns / 1ps

module joystick_servo_slew_drive_test;
  import jss_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam int unsigned PHASES       = 11;
  localparam int          FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
  localparam int          MID_SCALE    = 1 << (SAMPLE_BITS - 1);

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                   operation;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
  } joystick_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] level_x;
    logic [SAMPLE_BITS-1:0] level_y;
    logic [ANGLE_W-1:0]     position_x;
    logic [ANGLE_W-1:0]     position_y;
    logic [DUTY_W-1:0]      duty_x;
    logic [DUTY_W-1:0]      duty_y;
  } servo_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  jss_in_if  in_if ();
  jss_out_if out_if ();

  joystick_servo_slew_drive uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies and servo state as the block should hold them
  logic [7:0]               gain_cfg;
  logic [10:0]              deadzone_cfg;
  logic [9:0]               step_cfg;
  logic [9:0]               snap_cfg;
  logic signed [11:0]       trim_x_cfg;
  logic signed [11:0]       trim_y_cfg;
  logic [SAMPLE_BITS+7:0]   smooth_x_q;
  logic [SAMPLE_BITS+7:0]   smooth_y_q;
  int                       goal_x_q, goal_y_q, angle_x_q, angle_y_q;

  joystick_item_t joystick_items_pending[$];
  servo_result_t  servo_results_due[$];
  joystick_item_t offered_item;
  servo_result_t  due_result;
  bit             item_on_offer = 1'b0;
  int unsigned    send_gap_pct = 0;
  int unsigned    recv_gap_pct = 0;
  int unsigned    items_queued = 0;
  int unsigned    results_checked = 0;
  int unsigned    mismatches = 0;
  int unsigned    cycles = 0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Servo model
  // ---------------------------------------------------------------------------

  task automatic reset_model();
    gain_cfg     = RST_FILTER_GAIN;
    deadzone_cfg = RST_DEADZONE;
    step_cfg     = RST_SLEW_STEP;
    snap_cfg     = RST_SNAP;
    trim_x_cfg   = RST_TRIM_X;
    trim_y_cfg   = RST_TRIM_Y;
    smooth_x_q   = (SAMPLE_BITS+8)'(MID_SCALE << 8);
    smooth_y_q   = (SAMPLE_BITS+8)'(MID_SCALE << 8);
    goal_x_q     = int'(ANG_MID);
    goal_y_q     = int'(ANG_MID);
    angle_x_q    = int'(ANG_MID);
    angle_y_q    = int'(ANG_MID);
  endtask

  // Blend a new ADC value into the held filter value, 8 fraction bits
  function automatic logic [SAMPLE_BITS+7:0] smooth_next(logic [SAMPLE_BITS+7:0] held,
                                                          logic [SAMPLE_BITS-1:0] raw);
    longint unsigned h, r, g, acc;
    h   = held;
    r   = raw;
    g   = gain_cfg;
    acc = h * (256 - g) + (r << 8) * g;
    return (SAMPLE_BITS+8)'(acc >> 8);
  endfunction

  // Deadzone around mid scale, else a linear map onto 50..130 degrees
  function automatic int goal_from(logic [SAMPLE_BITS-1:0] level, bit mirror);
    int span;
    int mapped;
    span = int'(level) - MID_SCALE;
    if (span < 0) span = -span;
    if (span < int'(deadzone_cfg)) return int'(ANG_MID);
    mapped = int'(ANG_MIN)
           + int'((longint'(level) * longint'(ANG_MAX - ANG_MIN)) / FULL_SCALE);
    return mirror ? int'(ANG_MIRROR) - mapped : mapped;
  endfunction

  // Snap when close, else step towards the goal without overshoot
  function automatic int slew_toward(int pos, int goal);
    int span;
    span = goal - pos;
    if (span < 0) span = -span;
    if (span < int'(snap_cfg)) return goal;
    if (pos < goal) begin
      pos += int'(step_cfg);
      if (pos > goal) pos = goal;
    end else if (pos > goal) begin
      pos -= int'(step_cfg);
      if (pos < goal) pos = goal;
    end
    return pos;
  endfunction

  // 500..2500 us pulse over 0..180 degrees, as a 14-bit fraction of 20 ms
  function automatic logic [DUTY_W-1:0] duty_from(int pos, logic signed [11:0] trim);
    longint a;
    a = longint'(pos) + longint'(trim);
    if (a < longint'(ANG_MIN)) a = longint'(ANG_MIN);
    if (a > longint'(ANG_MAX)) a = longint'(ANG_MAX);
    return DUTY_W'(((500 * longint'(ANG_MIRROR) + 2000 * a) * 16383)
                   / (longint'(ANG_MIRROR) * 20000));
  endfunction

  // Advance the model by one transaction and return what the block reports
  function automatic servo_result_t advance_servo_model(joystick_item_t item);
    servo_result_t r;
    if (item.operation == OP_SAMPLE) begin
      smooth_x_q = smooth_next(smooth_x_q, item.sample_x);
      smooth_y_q = smooth_next(smooth_y_q, item.sample_y);
      goal_x_q   = goal_from(smooth_x_q[SAMPLE_BITS+7:8], 1'b1);
      goal_y_q   = goal_from(smooth_y_q[SAMPLE_BITS+7:8], 1'b0);
    end else begin
      angle_x_q = slew_toward(angle_x_q, goal_x_q);
      angle_y_q = slew_toward(angle_y_q, goal_y_q);
    end
    r.level_x    = smooth_x_q[SAMPLE_BITS+7:8];
    r.level_y    = smooth_y_q[SAMPLE_BITS+7:8];
    r.position_x = ANGLE_W'(angle_x_q);
    r.position_y = ANGLE_W'(angle_y_q);
    r.duty_x     = duty_from(angle_x_q, trim_x_cfg);
    r.duty_y     = duty_from(angle_y_q, trim_y_cfg);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string text);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch: %s", text);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, predict each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= OP_SAMPLE;
      in_if.sample_x  <= '0;
      in_if.sample_y  <= '0;
    end else begin
      // Record the expected result of an accepted transaction
      if (in_if.valid && in_if.ready) begin
        servo_results_due.push_back(
          advance_servo_model({in_if.operation, in_if.sample_x, in_if.sample_y}));
        item_on_offer = 1'b0;
      end
      // Offer the next item once the channel is free, with random gaps
      if (!in_if.valid || in_if.ready) begin
        if (joystick_items_pending.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          offered_item     = joystick_items_pending.pop_front();
          item_on_offer    = 1'b1;
          in_if.valid     <= 1'b1;
          in_if.operation <= offered_item.operation;
          in_if.sample_x  <= offered_item.sample_x;
          in_if.sample_y  <= offered_item.sample_y;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (servo_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result, position %0d/%0d",
                                    out_if.position_x, out_if.position_y));
        end else begin
          due_result = servo_results_due.pop_front();
          check_field("level_x", 32'(out_if.level_x), 32'(due_result.level_x));
          check_field("level_y", 32'(out_if.level_y), 32'(due_result.level_y));
          check_field("position_x", 32'(out_if.position_x), 32'(due_result.position_x));
          check_field("position_y", 32'(out_if.position_y), 32'(due_result.position_y));
          check_field("duty_x", 32'(out_if.duty_x), 32'(due_result.duty_x));
          check_field("duty_y", 32'(out_if.duty_y), 32'(due_result.duty_y));
        end
        results_checked++;
      end
      out_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [SAMPLE_BITS-1:0] clamp_level(int v);
    if (v < 0) v = 0;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return SAMPLE_BITS'(v);
  endfunction

  task automatic queue_item(logic op, logic [SAMPLE_BITS-1:0] sx,
                            logic [SAMPLE_BITS-1:0] sy);
    joystick_items_pending.push_back('{operation: op, sample_x: sx, sample_y: sy});
    items_queued++;
  endtask

  task automatic queue_tick();
    queue_item(OP_TICK, SAMPLE_BITS'($urandom_range(FULL_SCALE)),
               SAMPLE_BITS'($urandom_range(FULL_SCALE)));
  endtask

  // Stick position: an end stop, the deadzone edge, or anywhere
  function automatic logic [SAMPLE_BITS-1:0] pick_stick();
    int off;
    off = int'(deadzone_cfg) + $urandom_range(4) - 2;
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
      1:       return clamp_level($urandom_range(1) ? MID_SCALE + off : MID_SCALE - off);
      default: return SAMPLE_BITS'($urandom_range(FULL_SCALE));
    endcase
  endfunction

  task automatic queue_opening_items();
    queue_tick();
    repeat (3) queue_item(OP_SAMPLE, '0, '0);
    repeat (2) queue_tick();
    repeat (3) queue_item(OP_SAMPLE, SAMPLE_BITS'(FULL_SCALE), SAMPLE_BITS'(FULL_SCALE));
    repeat (2) queue_tick();
    queue_item(OP_SAMPLE, SAMPLE_BITS'(MID_SCALE), SAMPLE_BITS'(MID_SCALE));
    queue_item(OP_SAMPLE, SAMPLE_BITS'(MID_SCALE + int'(RST_DEADZONE)),
               SAMPLE_BITS'(MID_SCALE - int'(RST_DEADZONE)));
    queue_item(OP_SAMPLE, 12'hAAA, 12'h555);
    queue_item(OP_SAMPLE, 12'h555, 12'hAAA);
    repeat (3) queue_tick();
    queue_item(OP_SAMPLE, SAMPLE_BITS'(FULL_SCALE), '0);
    queue_tick();
  endtask

  // Mostly steady stick positions followed by slewing, some noise
  task automatic queue_random_items(int unsigned count);
    int unsigned            target;
    int unsigned            n;
    logic [SAMPLE_BITS-1:0] aim_x, aim_y;
    target = items_queued + count;
    while (items_queued < target) begin
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(4, 1))
            queue_item(1'($urandom_range(1)), SAMPLE_BITS'($urandom_range(FULL_SCALE)),
                       SAMPLE_BITS'($urandom_range(FULL_SCALE)));
        end
        8, 9: begin
          repeat ($urandom_range(20, 1)) queue_tick();
        end
        default: begin
          aim_x = pick_stick();
          aim_y = pick_stick();
          n     = $urandom_range(6, 1);
          repeat (n) begin
            queue_item(OP_SAMPLE, clamp_level(int'(aim_x) + $urandom_range(16) - 8),
                       clamp_level(int'(aim_y) + $urandom_range(16) - 8));
            if ($urandom_range(2) == 0) queue_tick();
          end
          repeat ($urandom_range(12, 1)) queue_tick();
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes
  // ---------------------------------------------------------------------------

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_FILTER_GAIN: gain_cfg     = value[7:0];
      REG_DEADZONE:    deadzone_cfg = value[10:0];
      REG_SLEW_STEP:   step_cfg     = value[9:0];
      REG_SNAP:        snap_cfg     = value[9:0];
      REG_TRIM_X:      trim_x_cfg   = value;
      REG_TRIM_Y:      trim_y_cfg   = value;
      default: ;
    endcase
  endtask

  task automatic program_registers(int unsigned gain, int unsigned dz, int unsigned step,
                                   int unsigned snap, int unsigned tx, int unsigned ty,
                                   bit spare);
    write_register(REG_FILTER_GAIN, CFG_W'(gain));
    write_register(REG_DEADZONE, CFG_W'(dz));
    write_register(REG_SLEW_STEP, CFG_W'(step));
    write_register(REG_SNAP, CFG_W'(snap));
    write_register(REG_TRIM_X, CFG_W'(tx));
    write_register(REG_TRIM_Y, CFG_W'(ty));
    // Writes to unmapped indexes must change nothing
    if (spare) begin
      write_register(REG_SPARE_LO, CFG_W'($urandom_range(4095)));
      write_register(REG_SPARE_HI, CFG_W'($urandom_range(4095)));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_until_idle();
    do @(posedge clk);
    while (joystick_items_pending.size() != 0 || item_on_offer
           || servo_results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned phase;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_FILTER_GAIN;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_SAMPLE;
    in_if.sample_x  = '0;
    in_if.sample_y  = '0;
    out_if.ready    = 1'b0;
    reset_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) wait_until_idle();
      // Sender rarely idle first, then the receiver, then neither
      if (phase < 4) begin
        send_gap_pct = 8;
        recv_gap_pct = 71;
      end else if (phase < 8) begin
        send_gap_pct = 71;
        recv_gap_pct = 8;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (phase)
        0: queue_opening_items();
        1: begin
          program_registers(255, 0, 1023, 0, 12'h7FF, 12'h800, 1'b0);
          queue_random_items(90);
        end
        2: begin
          program_registers(0, 1, 0, 1023, 12'h800, 12'h7FF, 1'b1);
          queue_random_items(60);
        end
        PHASES - 1: begin
          program_registers(200, 2047, 1, 0, 0, 0, 1'b0);
          queue_random_items(80);
        end
        default: begin
          program_registers(
            $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(255, 64),
            $urandom_range(3) == 0 ? $urandom_range(2047) : $urandom_range(600),
            $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(300, 1),
            $urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(64),
            $urandom_range(4095), $urandom_range(4095), $urandom_range(2) == 0);
          queue_random_items(75);
        end
      endcase
    end

    // Drain, then allow for any stray result
    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && servo_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/jss_pkg.sv
hw/rtl/jss_if.sv
hw/rtl/jss_lane.sv
hw/rtl/jss_merge.sv
hw/rtl/joystick_servo_slew_drive.sv
tb/joystick_servo_slew_drive_test.sv
